// ===== src/btff_pkg.sv =====
`default_nettype none

package btff_pkg;

   localparam int KIND_W   = 1;
   localparam int REQ_W    = 19;
   localparam int ADDR_W   = 18;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 19;
   localparam int TAG_W    = 32;
   localparam int OFF_W    = 36;
   localparam int SIZE_W   = 20;
   localparam int GROW_W   = 21;

   localparam int HEAP_WORDS_DEFAULT = 65536;
   localparam int ADDR_SPAN          = 262144;
   localparam int INIT_CHUNK         = 4096;
   localparam int MIN_BLOCK          = 16;
   localparam int BREAK_RESET        = 16 + INIT_CHUNK;
   localparam int LIMIT_RESET        = ADDR_SPAN;
   localparam int GROW_RESET         = INIT_CHUNK;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

   localparam logic CSR_HEAP_LIMIT = 1'b0;
   localparam logic CSR_GROW       = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZERO = 2'd1,
      STATUS_OOM  = 2'd2
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [REQ_W-1:0]  request_bytes;
      logic [ADDR_W-1:0] block_addr;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_addr;
      status_type        status;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } done_type;

   // Heap image after reset: padding, prologue, one free chunk, epilogue.
   function automatic logic [TAG_W-1:0] init_word(input logic [31:0] widx);
      logic [TAG_W-1:0] w;
      w = '0;
      unique case (widx)
         32'd1, 32'd2: w = TAG_W'(9);
         32'd3: w = TAG_W'(INIT_CHUNK);
         32'(3 + INIT_CHUNK / 4 - 1): w = TAG_W'(INIT_CHUNK);
         32'(3 + INIT_CHUNK / 4): w = TAG_W'(1);
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== src/btff_if.sv =====
`default_nettype none

interface btff_req_if;
   logic                                valid;
   logic                                ready;
   logic [btff_pkg::KIND_W-1:0]         kind;
   logic [btff_pkg::REQ_W-1:0]          request_bytes;
   logic [btff_pkg::ADDR_W-1:0]         block_addr;

   modport source(output valid, kind, request_bytes, block_addr, input ready);
   modport sink(input valid, kind, request_bytes, block_addr, output ready);
endinterface

interface btff_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [btff_pkg::ADDR_W-1:0]         result_addr;
   logic [btff_pkg::STATUS_W-1:0]       status;

   modport source(output valid, result_addr, status, input ready);
   modport sink(input valid, result_addr, status, output ready);
endinterface

`default_nettype wire

// ===== src/btff_ram.sv =====
`default_nettype none

module btff_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/btff_engine.sv =====
`default_nettype none

module btff_engine #(
   parameter int HEAP_WORDS = btff_pkg::HEAP_WORDS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [btff_pkg::CFG_W-1:0]  heap_limit,
   input  wire logic [btff_pkg::CFG_W-1:0]  grow_min,
   input  wire logic                        req_valid,
   input  wire btff_pkg::req_item_type      req_item,
   output logic                             req_ready,
   input  wire logic                        rsp_free,
   output btff_pkg::done_type               done
);

   localparam int AW     = $clog2(HEAP_WORDS);
   localparam int OFF_W  = btff_pkg::OFF_W;
   localparam int TAG_W  = btff_pkg::TAG_W;
   localparam int SIZE_W = btff_pkg::SIZE_W;
   localparam int GROW_W = btff_pkg::GROW_W;
   localparam int CFG_W  = btff_pkg::CFG_W;
   localparam longint STORE_BYTES = longint'(HEAP_WORDS) * 4;
   localparam longint LIM_CAP = (STORE_BYTES < btff_pkg::ADDR_SPAN) ?
                                STORE_BYTES : btff_pkg::ADDR_SPAN;

   localparam logic [OFF_W-1:0] OFF4  = OFF_W'(4);
   localparam logic [OFF_W-1:0] OFF8  = OFF_W'(8);

   typedef enum logic [30:0] {
      S_INIT  = 31'(1) << 0,
      S_IDLE  = 31'(1) << 1,
      S_FF    = 31'(1) << 2,
      S_GROW  = 31'(1) << 3,
      S_G1    = 31'(1) << 4,
      S_G2    = 31'(1) << 5,
      S_FR1   = 31'(1) << 6,
      S_FR2   = 31'(1) << 7,
      S_MG1   = 31'(1) << 8,
      S_MG2   = 31'(1) << 9,
      S_MG3   = 31'(1) << 10,
      S_MG4   = 31'(1) << 11,
      S_MG5   = 31'(1) << 12,
      S_MG6   = 31'(1) << 13,
      S_MP2   = 31'(1) << 14,
      S_MN2   = 31'(1) << 15,
      S_MN3   = 31'(1) << 16,
      S_MB1   = 31'(1) << 17,
      S_MB2   = 31'(1) << 18,
      S_MB3   = 31'(1) << 19,
      S_MB4   = 31'(1) << 20,
      S_MB5   = 31'(1) << 21,
      S_MB6   = 31'(1) << 22,
      S_MEND  = 31'(1) << 23,
      S_P0    = 31'(1) << 24,
      S_P1    = 31'(1) << 25,
      S_P2    = 31'(1) << 26,
      S_P3    = 31'(1) << 27,
      S_P4    = 31'(1) << 28,
      S_P5    = 31'(1) << 29,
      S_DONE  = 31'(1) << 30
   } state_type;

   function automatic logic is_oor(input logic [OFF_W-1:0] off);
      return off[OFF_W-1] || (off[OFF_W-1:2] >= (OFF_W-2)'(HEAP_WORDS));
   endfunction

   function automatic logic [OFF_W-1:0] ext32(input logic [TAG_W-1:0] v);
      return {{(OFF_W-TAG_W){1'b0}}, v};
   endfunction

   state_type                 state_ff, state_in;
   logic [AW-1:0]             init_idx_ff, init_idx_in;
   logic [CFG_W-1:0]          break_ff, break_in;
   logic [OFF_W-1:0]          bp_ff, bp_in;
   logic [OFF_W-1:0]          p_ff, p_in;
   logic [OFF_W-1:0]          n_ff, n_in;
   logic [TAG_W-1:0]          bsz_ff, bsz_in;
   logic [TAG_W-1:0]          psz_ff, psz_in;
   logic [TAG_W-1:0]          sz_ff, sz_in;
   logic [TAG_W-1:0]          csize_ff, csize_in;
   logic                      pa_ff, pa_in;
   logic                      hdr_oor_ff, hdr_oor_in;
   logic [SIZE_W-1:0]         asize_ff, asize_in;
   logic [GROW_W-1:0]         gsz_ff, gsz_in;
   logic [btff_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [btff_pkg::ADDR_W-1:0] addr_ff, addr_in;
   btff_pkg::status_type      status_ff, status_in;
   logic                      rd_oor_ff;

   logic [OFF_W-1:0]          rd_off;
   logic                      wr_en;
   logic [OFF_W-1:0]          wr_off;
   logic [TAG_W-1:0]          wr_data;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [TAG_W-1:0]          ram_wdata;
   logic [TAG_W-1:0]          ram_rdata;

   logic [TAG_W-1:0]          tag;
   logic [OFF_W-1:0]          tsz;
   logic                      talloc;
   logic [CFG_W-1:0]          lim;
   logic [SIZE_W-1:0]         req_asize;
   logic [SIZE_W-1:0]         grow_ext;
   logic [GROW_W-3:0]         grow_w;
   logic [OFF_W-1:0]          off_tmp;
   logic                      free_ok;

   // Out-of-store reads return zero.
   assign tag    = rd_oor_ff ? '0 : ram_rdata;
   assign tsz    = ext32({tag[TAG_W-1:3], 3'b000});
   assign talloc = tag[0];

   assign lim = (heap_limit < CFG_W'(LIM_CAP)) ? heap_limit : CFG_W'(LIM_CAP);

   // Requests of one byte or more always come out at least sixteen bytes.
   assign req_asize = ((SIZE_W'(req_item.request_bytes) + SIZE_W'(7)) & ~SIZE_W'(7))
                      + SIZE_W'(8);
   assign grow_ext  = (asize_ff > SIZE_W'(grow_min)) ? asize_ff : SIZE_W'(grow_min);
   assign grow_w    = (GROW_W-2)'(grow_ext[SIZE_W-1:2]) + (GROW_W-2)'(grow_ext[2]);

   assign free_ok = (req_item.block_addr[2:0] == 3'b000) &&
                    (req_item.block_addr >= btff_pkg::ADDR_W'(16)) &&
                    (CFG_W'(req_item.block_addr) < break_ff);

   always_comb begin
      state_in    = state_ff;
      init_idx_in = init_idx_ff;
      break_in    = break_ff;
      bp_in       = bp_ff;
      p_in        = p_ff;
      n_in        = n_ff;
      bsz_in      = bsz_ff;
      psz_in      = psz_ff;
      sz_in       = sz_ff;
      csize_in    = csize_ff;
      pa_in       = pa_ff;
      hdr_oor_in  = hdr_oor_ff;
      asize_in    = asize_ff;
      gsz_in      = gsz_ff;
      kind_in     = kind_ff;
      addr_in     = addr_ff;
      status_in   = status_ff;
      rd_off      = '0;
      wr_en       = 1'b0;
      wr_off      = '0;
      wr_data     = '0;
      off_tmp     = '0;
      req_ready   = 1'b0;
      done        = '0;

      unique case (state_ff)
         S_INIT: begin
            init_idx_in = init_idx_ff + AW'(1);
            if (init_idx_ff == AW'(HEAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = req_item.kind;
               addr_in   = '0;
               status_in = btff_pkg::STATUS_OK;
               if (req_item.kind == btff_pkg::KIND_ALLOC) begin
                  if (req_item.request_bytes == '0) begin
                     status_in = btff_pkg::STATUS_ZERO;
                     state_in  = S_DONE;
                  end else begin
                     asize_in = req_asize;
                     bp_in    = OFF8;
                     rd_off   = OFF4;
                     state_in = S_FF;
                  end
               end else begin
                  bp_in = OFF_W'(req_item.block_addr);
                  if (free_ok) begin
                     rd_off   = OFF_W'(req_item.block_addr) - OFF4;
                     state_in = S_FR1;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_FF: begin
            // one header per cycle: test it and fetch the next
            off_tmp = bp_ff + tsz;
            if (tsz == '0) begin
               state_in = S_GROW;
            end else if (!talloc && (OFF_W'(asize_ff) <= tsz)) begin
               state_in = S_P0;
            end else if (off_tmp > OFF_W'(break_ff)) begin
               state_in = S_GROW;
            end else begin
               bp_in  = off_tmp;
               rd_off = off_tmp - OFF4;
            end
         end
         S_GROW: begin
            gsz_in = {grow_w, 2'b00};
            bp_in  = OFF_W'(break_ff);
            if ((OFF_W'(break_ff) + OFF_W'({grow_w, 2'b00})) > OFF_W'(lim)) begin
               status_in = btff_pkg::STATUS_OOM;
               state_in  = S_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_off   = OFF_W'(break_ff) - OFF4;
               wr_data  = TAG_W'({grow_w, 2'b00});
               state_in = S_G1;
            end
         end
         S_G1: begin
            wr_en    = 1'b1;
            wr_off   = bp_ff + OFF_W'(gsz_ff) - OFF8;
            wr_data  = TAG_W'(gsz_ff);
            state_in = S_G2;
         end
         S_G2: begin
            wr_en    = 1'b1;
            wr_off   = bp_ff + OFF_W'(gsz_ff) - OFF4;
            wr_data  = TAG_W'(1);
            break_in = CFG_W'(bp_ff + OFF_W'(gsz_ff));
            state_in = S_MG1;
         end
         S_FR1: begin
            bsz_in     = tsz[TAG_W-1:0];
            hdr_oor_in = rd_oor_ff;
            wr_en      = 1'b1;
            wr_off     = bp_ff - OFF4;
            wr_data    = tsz[TAG_W-1:0];
            state_in   = S_FR2;
         end
         S_FR2: begin
            wr_en    = 1'b1;
            wr_off   = bp_ff + (hdr_oor_ff ? '0 : ext32(bsz_ff)) - OFF8;
            wr_data  = bsz_ff;
            state_in = S_MG1;
         end
         S_MG1: begin
            rd_off   = bp_ff - OFF8;
            state_in = S_MG2;
         end
         S_MG2: begin
            p_in     = bp_ff - tsz;
            rd_off   = bp_ff - tsz - OFF4;
            state_in = S_MG3;
         end
         S_MG3: begin
            psz_in   = tsz[TAG_W-1:0];
            rd_off   = p_ff + tsz - OFF8;
            state_in = S_MG4;
         end
         S_MG4: begin
            pa_in    = talloc;
            rd_off   = bp_ff - OFF4;
            state_in = S_MG5;
         end
         S_MG5: begin
            bsz_in     = tsz[TAG_W-1:0];
            hdr_oor_in = rd_oor_ff;
            n_in       = bp_ff + tsz;
            rd_off     = bp_ff + tsz - OFF4;
            state_in   = S_MG6;
         end
         S_MG6: begin
            priority if (pa_ff && talloc) begin
               state_in = S_MEND;
            end else if (pa_ff) begin
               sz_in    = bsz_ff + tsz[TAG_W-1:0];
               wr_en    = 1'b1;
               wr_off   = bp_ff - OFF4;
               wr_data  = bsz_ff + tsz[TAG_W-1:0];
               state_in = S_MP2;
            end else if (talloc) begin
               sz_in    = bsz_ff + psz_ff;
               wr_en    = 1'b1;
               wr_off   = bp_ff + ext32(bsz_ff) - OFF8;
               wr_data  = bsz_ff + psz_ff;
               state_in = S_MN2;
            end else begin
               rd_off   = n_ff + tsz - OFF8;
               state_in = S_MB1;
            end
         end
         S_MP2: begin
            wr_en    = 1'b1;
            wr_off   = bp_ff + (hdr_oor_ff ? '0 : ext32({sz_ff[TAG_W-1:3], 3'b000})) - OFF8;
            wr_data  = sz_ff;
            state_in = S_MEND;
         end
         S_MN2: begin
            rd_off   = bp_ff - OFF8;
            state_in = S_MN3;
         end
         S_MN3: begin
            wr_en    = 1'b1;
            wr_off   = bp_ff - tsz - OFF4;
            wr_data  = sz_ff;
            bp_in    = bp_ff - tsz;
            state_in = S_MEND;
         end
         S_MB1: begin
            sz_in    = bsz_ff + psz_ff + tsz[TAG_W-1:0];
            wr_en    = 1'b1;
            wr_off   = p_ff - OFF4;
            wr_data  = bsz_ff + psz_ff + tsz[TAG_W-1:0];
            state_in = S_MB2;
         end
         S_MB2: begin
            rd_off   = bp_ff - OFF4;
            state_in = S_MB3;
         end
         S_MB3: begin
            n_in     = bp_ff + tsz;
            rd_off   = bp_ff + tsz - OFF4;
            state_in = S_MB4;
         end
         S_MB4: begin
            wr_en    = 1'b1;
            wr_off   = n_ff + tsz - OFF8;
            wr_data  = sz_ff;
            state_in = S_MB5;
         end
         S_MB5: begin
            rd_off   = bp_ff - OFF8;
            state_in = S_MB6;
         end
         S_MB6: begin
            bp_in    = bp_ff - tsz;
            state_in = S_MEND;
         end
         S_MEND: begin
            // after a grow the merged block is placed; a free is finished
            if (kind_ff == btff_pkg::KIND_ALLOC) begin
               // a merge that lands on offset zero counts as out of memory
               if (bp_ff == '0) begin
                  status_in = btff_pkg::STATUS_OOM;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_P0;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_P0: begin
            rd_off   = bp_ff - OFF4;
            state_in = S_P1;
         end
         S_P1: begin
            csize_in   = tsz[TAG_W-1:0];
            hdr_oor_in = rd_oor_ff;
            wr_en      = 1'b1;
            wr_off     = bp_ff - OFF4;
            if (tsz >= OFF_W'(asize_ff) + OFF_W'(btff_pkg::MIN_BLOCK)) begin
               wr_data  = TAG_W'(asize_ff) | TAG_W'(1);
               state_in = S_P2;
            end else begin
               wr_data  = tsz[TAG_W-1:0] | TAG_W'(1);
               state_in = S_P5;
            end
         end
         S_P2: begin
            wr_en    = 1'b1;
            wr_off   = bp_ff + (hdr_oor_ff ? '0 : OFF_W'(asize_ff)) - OFF8;
            wr_data  = TAG_W'(asize_ff) | TAG_W'(1);
            state_in = S_P3;
         end
         S_P3: begin
            n_in     = bp_ff + (hdr_oor_ff ? '0 : OFF_W'(asize_ff));
            wr_en    = 1'b1;
            wr_off   = bp_ff + (hdr_oor_ff ? '0 : OFF_W'(asize_ff)) - OFF4;
            wr_data  = csize_ff - TAG_W'(asize_ff);
            state_in = S_P4;
         end
         S_P4: begin
            off_tmp  = ext32(csize_ff - TAG_W'(asize_ff));
            wr_en    = 1'b1;
            wr_off   = n_ff + (is_oor(n_ff - OFF4) ? '0 : off_tmp) - OFF8;
            wr_data  = csize_ff - TAG_W'(asize_ff);
            addr_in  = bp_ff[btff_pkg::ADDR_W-1:0];
            state_in = S_DONE;
         end
         S_P5: begin
            wr_en    = 1'b1;
            wr_off   = bp_ff + (hdr_oor_ff ? '0 : ext32(csize_ff)) - OFF8;
            wr_data  = csize_ff | TAG_W'(1);
            addr_in  = bp_ff[btff_pkg::ADDR_W-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            done.valid            = rsp_free;
            done.item.result_addr = addr_ff;
            done.item.status      = status_ff;
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Drop writes beyond the store; during init sweep the image.
   always_comb begin
      if (state_ff == S_INIT) begin
         ram_we    = 1'b1;
         ram_waddr = init_idx_ff;
         ram_wdata = btff_pkg::init_word(32'(init_idx_ff));
      end else begin
         ram_we    = wr_en && !is_oor(wr_off);
         ram_waddr = wr_off[AW+1:2];
         ram_wdata = wr_data;
      end
   end

   btff_ram #(
      .WIDTH(TAG_W),
      .DEPTH(HEAP_WORDS)
   ) u_tag_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(rd_off[AW+1:2]),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         init_idx_ff <= '0;
         break_ff    <= CFG_W'(btff_pkg::BREAK_RESET);
      end else begin
         state_ff    <= state_in;
         init_idx_ff <= init_idx_in;
         break_ff    <= break_in;
      end
   end

   always_ff @(posedge clock) begin
      bp_ff      <= bp_in;
      p_ff       <= p_in;
      n_ff       <= n_in;
      bsz_ff     <= bsz_in;
      psz_ff     <= psz_in;
      sz_ff      <= sz_in;
      csize_ff   <= csize_in;
      pa_ff      <= pa_in;
      hdr_oor_ff <= hdr_oor_in;
      asize_ff   <= asize_in;
      gsz_ff     <= gsz_in;
      kind_ff    <= kind_in;
      addr_ff    <= addr_in;
      status_ff  <= status_in;
      rd_oor_ff  <= is_oor(rd_off);
   end

   a_break_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> break_ff >= $past(break_ff))
      else $error("heap break moved down");

   a_ram_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, ram_waddr} < (AW+1)'(HEAP_WORDS)))
      else $error("tag write outside the store");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      done.valid && done.item.status != btff_pkg::STATUS_OK |->
      done.item.result_addr == '0)
      else $error("refused request carries an address");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !ram_we)
      else $error("tag write while idle");

endmodule

`default_nettype wire

// ===== src/boundary_tag_first_fit_allocator_top.sv =====
// An allocate walks the block headers first fit and places the block; if none fits, the heap
//   is extended and merged with its free neighbours first, or out of memory is returned.
// A free merges the block with its free neighbours; a zero-size or ignored request touches no
//   tag. One tag access per cycle on the single tag RAM keeps one item in work at a time.
// Reset sweeps the heap image into the tag RAM, one word a cycle, with the input not ready;
//   configuration writes are taken throughout.
`default_nettype none

module boundary_tag_first_fit_allocator_top #(
   parameter int HEAP_WORDS = btff_pkg::HEAP_WORDS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   btff_req_if.sink                        req_bus,
   btff_rsp_if.source                      rsp_bus,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [btff_pkg::CFG_W-1:0] csr_wdata
);

   logic [btff_pkg::CFG_W-1:0] heap_limit_ff;
   logic [btff_pkg::CFG_W-1:0] grow_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   btff_pkg::rsp_item_type     rsp_item_ff;
   btff_pkg::req_item_type     req_item;
   btff_pkg::done_type         done;
   logic                       req_ready;
   logic                       rsp_free;

   assign req_item.kind          = req_bus.kind;
   assign req_item.request_bytes = req_bus.request_bytes;
   assign req_item.block_addr    = req_bus.block_addr;
   assign req_bus.ready          = req_ready;

   // The output slot frees when empty or when its beat leaves this cycle.
   assign rsp_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = done.valid || (rsp_valid_ff && !rsp_bus.ready);

   btff_engine #(
      .HEAP_WORDS(HEAP_WORDS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .heap_limit(heap_limit_ff),
      .grow_min(grow_ff),
      .req_valid(req_bus.valid),
      .req_item(req_item),
      .req_ready(req_ready),
      .rsp_free(rsp_free),
      .done(done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= btff_pkg::CFG_W'(btff_pkg::LIMIT_RESET);
         grow_ff       <= btff_pkg::CFG_W'(btff_pkg::GROW_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               btff_pkg::CSR_HEAP_LIMIT: heap_limit_ff <= csr_wdata;
               btff_pkg::CSR_GROW:       grow_ff       <= csr_wdata;
               default:                  heap_limit_ff <= heap_limit_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_item_ff <= done.item;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_addr = rsp_item_ff.result_addr;
   assign rsp_bus.status      = rsp_item_ff.status;

endmodule

`default_nettype wire
